// ===== hw/rtl/msgd_pkg.sv =====
package msgd_pkg;

    // word and fraction widths of the Q16.16 format
    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int unsigned REQ_ACCUM  = 0;
    localparam int unsigned REQ_CLOSE  = 1;
    localparam int unsigned REQ_UPDATE = 2;
    localparam int unsigned REQ_END    = 3;

    localparam logic [2:0] CFG_CLIP_EN  = 3'd0;
    localparam logic [2:0] CFG_CLIP_THR = 3'd1;
    localparam logic [2:0] CFG_LRATE    = 3'd2;
    localparam logic [2:0] CFG_WDECAY   = 3'd3;
    localparam logic [2:0] CFG_MOMENTUM = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] weight;
        logic signed [31:0] gradient;
        logic signed [31:0] velocity;
        logic [15:0]        step_scale;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_weight;
        logic signed [31:0] new_velocity;
        logic               was_clipped;
        logic [31:0]        clip_total;
        logic [31:0]        update_total;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input item, start its work
        logic step_sq;   // one square-root iteration
        logic step_div;  // one division iteration
        logic start_div; // set up division after the root
        logic mul_a;     // first update product stage
        logic mul_b;     // second update product stage
        logic mul_c;     // third update product stage
        logic finish;    // commit state, build result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] kind;
        logic       need_clip;
        logic       sq_done;
        logic       div_done;
    } t_dp_sts;

endpackage

// ===== hw/rtl/msgd_ctrl.sv =====
module msgd_ctrl
    import msgd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_DEC  = 4'd1;
    localparam logic [3:0] ST_SQ   = 4'd2;
    localparam logic [3:0] ST_CHK  = 4'd3;
    localparam logic [3:0] ST_DIV  = 4'd4;
    localparam logic [3:0] ST_MA   = 4'd5;
    localparam logic [3:0] ST_MB   = 4'd6;
    localparam logic [3:0] ST_MC   = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0] r_state, n_state;
    logic       w_take;

    // accept when idle, or when the held result leaves this cycle
    assign o_in_stall  = !((r_state == ST_IDLE) || (r_state == ST_OUT && !i_out_stall));
    assign w_take      = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == ST_OUT);

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = w_take;
        n_state    = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_take) n_state = ST_DEC;
            end
            ST_DEC: begin
                unique case (i_sts.kind)
                    2'(REQ_CLOSE):  n_state = ST_SQ;
                    2'(REQ_UPDATE): n_state = ST_MA;
                    default:        n_state = ST_FIN;
                endcase
            end
            ST_SQ: begin
                o_cmd.step_sq = 1'b1;
                if (i_sts.sq_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.need_clip) begin
                    o_cmd.start_div = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_DIV: begin
                o_cmd.step_div = 1'b1;
                if (i_sts.div_done) n_state = ST_FIN;
            end
            ST_MA: begin
                o_cmd.mul_a = 1'b1;
                n_state = ST_MB;
            end
            ST_MB: begin
                o_cmd.mul_b = 1'b1;
                n_state = ST_MC;
            end
            ST_MC: begin
                o_cmd.mul_c = 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!i_out_stall) n_state = w_take ? ST_DEC : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/msgd_dpath.sv =====
module msgd_dpath
    import msgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  t_in_item    i_item,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output t_out_item   o_item
);

    localparam int FB = FRAC_BITS;
    localparam int SQ_STEPS = 32;
    localparam int DIV_BITS = 31 + FB;

    // configuration
    logic        r_clip_en;
    logic [30:0] r_clip_thr;
    logic [15:0] r_lrate, r_wdecay, r_mom;

    // architectural state
    logic [63:0] r_sum;
    logic [FB:0] r_factor;
    logic [31:0] r_clip_cnt, r_upd_cnt;

    // captured item
    t_in_item    r_it;

    // square root working registers
    logic [63:0] r_rx, r_rres, r_rbit;
    logic [5:0]  r_sq_cnt;

    // divider working registers
    logic [DIV_BITS-1:0] r_quo;
    logic [32:0]         r_rem;
    logic [5:0]          r_div_cnt;

    // update products
    logic signed [63:0] r_sg, r_mv, r_reg, r_step, r_nv;
    logic [31:0]        r_coef;

    t_out_item r_out;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_en  <= 1'b1;
            r_clip_thr <= 31'd327680;
            r_lrate    <= 16'd6554;
            r_wdecay   <= 16'd0;
            r_mom      <= 16'd58982;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLIP_EN:  r_clip_en  <= i_cfg_data[0];
                CFG_CLIP_THR: r_clip_thr <= i_cfg_data;
                CFG_LRATE:    r_lrate    <= i_cfg_data[15:0];
                CFG_WDECAY:   r_wdecay   <= i_cfg_data[15:0];
                CFG_MOMENTUM: r_mom      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // combinational helpers
    logic [63:0] w_mag, w_sq, w_sum_add;
    logic [64:0] w_sum_wide;
    logic [63:0] w_trial;
    logic [32:0] w_rem_sh;

    assign w_mag      = r_it.gradient[31] ? 64'(-{{32{r_it.gradient[31]}}, r_it.gradient})
                                          : 64'(r_it.gradient);
    assign w_sq       = w_mag[31:0] * w_mag[31:0] + ((w_mag[32]) ? 64'h4000_0000_0000_0000 : 64'd0);
    assign w_sum_wide = {1'b0, r_sum} + {1'b0, w_sq};
    assign w_sum_add  = w_sum_wide[64] ? '1 : w_sum_wide[63:0];
    assign w_trial    = r_rres + r_rbit;
    assign w_rem_sh   = {r_rem[31:0], r_quo[DIV_BITS-1]};

    function automatic logic signed [63:0] sat(input logic signed [63:0] x);
        logic signed [63:0] hi, lo;
        hi = 64'((64'sd1 <<< (WORD_BITS - 1)) - 1);
        lo = -hi - 64'sd1;
        if (x > hi) return hi;
        if (x < lo) return lo;
        return x;
    endfunction

    logic signed [63:0] w_nw64;
    assign w_nw64 = sat(64'(r_it.weight) + r_nv - r_reg);

    assign o_sts.kind      = r_it.req_type;
    assign o_sts.need_clip = r_clip_en && (r_rres > 64'(r_clip_thr));
    assign o_sts.sq_done   = (r_sq_cnt == 6'(SQ_STEPS - 1));
    assign o_sts.div_done  = (r_div_cnt == 6'(DIV_BITS - 1));

    // working datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_it     <= i_item;
            r_rx     <= r_sum;
            r_rres   <= '0;
            r_rbit   <= 64'h4000_0000_0000_0000;
            r_sq_cnt <= '0;
        end
        // bit-pair square root, one result bit per cycle
        if (i_cmd.step_sq) begin
            if (r_rx >= w_trial) begin
                r_rx   <= r_rx - w_trial;
                r_rres <= (r_rres >> 1) + r_rbit;
            end else begin
                r_rres <= r_rres >> 1;
            end
            r_rbit   <= r_rbit >> 2;
            r_sq_cnt <= r_sq_cnt + 6'd1;
        end
        // restoring divide of threshold << FB by the norm
        if (i_cmd.start_div) begin
            r_quo     <= {r_clip_thr, {FB{1'b0}}};
            r_rem     <= '0;
            r_div_cnt <= '0;
        end
        if (i_cmd.step_div) begin
            if (w_rem_sh >= r_rres[32:0]) begin
                r_rem <= w_rem_sh - r_rres[32:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + 6'd1;
        end
        // update products, one multiplier level per cycle
        if (i_cmd.mul_a) begin
            r_sg   <= (64'(r_it.gradient) * 64'(signed'({1'b0, r_factor}))) >>> FB;
            r_coef <= r_lrate * r_it.step_scale;
            r_mv   <= (64'(signed'({1'b0, r_mom})) * 64'(r_it.velocity)) >>> 16;
            r_reg  <= (64'(signed'({1'b0, r_wdecay})) * 64'(r_it.weight)) >>> 16;
        end
        if (i_cmd.mul_b) begin
            r_step <= (r_sg * 64'(signed'({1'b0, r_coef}))) >>> 24;
        end
        // saturate the new velocity
        if (i_cmd.mul_c) begin
            r_nv <= sat(r_mv - r_step);
        end
    end

    // commit architectural state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_factor   <= (FB+1)'(1) << FB;
            r_clip_cnt <= '0;
            r_upd_cnt  <= '0;
        end else if (i_cmd.finish) begin
            case (r_it.req_type)
                2'(REQ_ACCUM): r_sum <= w_sum_add;
                2'(REQ_CLOSE): begin
                    if (o_sts.need_clip) begin
                        r_factor   <= r_quo[FB:0];
                        r_clip_cnt <= r_clip_cnt + 32'd1;
                    end else begin
                        r_factor <= (FB+1)'(1) << FB;
                    end
                end
                2'(REQ_END): begin
                    r_upd_cnt <= r_upd_cnt + 32'd1;
                    r_sum     <= '0;
                    r_factor  <= (FB+1)'(1) << FB;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.was_clipped  <= (r_it.req_type == 2'(REQ_CLOSE)) && o_sts.need_clip;
            r_out.clip_total   <= r_clip_cnt
                + 32'((r_it.req_type == 2'(REQ_CLOSE)) && o_sts.need_clip);
            r_out.update_total <= r_upd_cnt + 32'(r_it.req_type == 2'(REQ_END));
            if (r_it.req_type == 2'(REQ_UPDATE)) begin
                r_out.new_velocity <= r_nv[31:0];
                r_out.new_weight   <= w_nw64[31:0];
            end else begin
                r_out.new_velocity <= '0;
                r_out.new_weight   <= '0;
            end
        end
    end

    assign o_item = r_out;

endmodule

// ===== hw/rtl/momentum_sgd_update_with_clipping.sv =====
// Fixed-point SGD-with-momentum engine, one result per item. Accumulate and end
// items pass through decode and finish; update items also pass the multiply states. A
// close-norm item runs the bit-serial square root (32 steps) and, when it clips,
// the bit-serial divider (47 steps), both sharing the datapath.
// A new item is taken in the cycle its predecessor's result leaves.
module momentum_sgd_update_with_clipping
    import msgd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    msgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    msgd_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_item     (o_out_data)
    );

endmodule
